@@ rtl/core/pa_pkg.sv @@
// shared types, constants and codes for the page allocator
package pa_pkg;

  localparam int PAGES      = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int IDX_W      = $clog2(PAGES);
  localparam int CNT_W      = $clog2(PAGES + 1);
  localparam int OFF_W      = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 32;
  localparam int NUM_W      = 11;
  localparam int LIM_W      = 11;
  localparam int REF_W      = 16;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INC   = 2'd2;
  localparam logic [1:0] CMD_DEC   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD     = 3'd3;
  localparam logic [STAT_W-1:0] ST_SAT     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUMP_LIMIT = 1'd1;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
    logic [NUM_W-1:0]  page_count;
  } pa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [STAT_W-1:0] status;
    logic [REF_W-1:0]  ref_count;
  } pa_rsp_t;

  typedef struct packed {
    logic             free_ok;
    logic             ref_ok;
    logic [IDX_W-1:0] page_idx;
  } pa_dec_t;

endpackage

@@ rtl/core/pa_ram.sv @@
// generic simple dual port ram with registered read
module pa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pa_decode.sv @@
// address range and alignment checks for free and reference commands
module pa_decode (
  input  pa_pkg::pa_req_t            req,
  input  logic [pa_pkg::ADDR_W-1:0]  pool_base,
  output pa_pkg::pa_dec_t            dec
);

  logic [pa_pkg::ADDR_W-1:0] off;
  logic [pa_pkg::ADDR_W:0]   run_end;
  logic [pa_pkg::ADDR_W:0]   pool_end;
  logic                      below;
  logic                      aligned;

  always_comb begin
    off      = req.address - pool_base;
    below    = req.address < pool_base;
    aligned  = off[pa_pkg::OFF_W-1:0] == '0;
    run_end  = {1'b0, req.address}
             + ((pa_pkg::ADDR_W+1)'(req.page_count) << pa_pkg::OFF_W);
    pool_end = {1'b0, pool_base}
             + ((pa_pkg::ADDR_W+1)'(pa_pkg::PAGES) << pa_pkg::OFF_W);
    dec.free_ok  = (req.page_count != '0) && !below && aligned && (run_end <= pool_end);
    dec.ref_ok   = !below && aligned
                 && ((off >> pa_pkg::OFF_W) < pa_pkg::ADDR_W'(pa_pkg::PAGES));
    dec.page_idx = off[pa_pkg::OFF_W +: pa_pkg::IDX_W];
  end

endmodule

@@ rtl/core/page_allocator_refcount.sv @@
// top level of the first fit page allocator with reference counts
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_data  (command, address, page_count)
//  out       output     out_valid/out_stall  out_data (result_address, status, ref_count)
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// after reset a clearing pass writes zero to all PAGES counts
// one item at a time: in_stall stays high until the sequencer is back in idle
// the single read port of the count ram sets the rate: one page per cycle
// a finished result sits in the output register, the next item is taken meanwhile
module page_allocator_refcount (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pa_pkg::pa_req_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pa_pkg::pa_rsp_t                  out_data,
  input  logic                             cfg_we,
  input  logic [pa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pa_pkg::ADDR_W-1:0]        cfg_data
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_BUMP   = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FDEC   = 4'd7;
  localparam logic [3:0] S_RREAD  = 4'd8;
  localparam logic [3:0] S_RMW    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]                   state;
  logic [pa_pkg::ADDR_W-1:0]    pool_base;
  logic [pa_pkg::LIM_W-1:0]     bump_limit;
  logic [pa_pkg::CNT_W-1:0]     frontier;

  // latched item and its decode
  pa_pkg::pa_req_t              req;
  pa_pkg::pa_dec_t              dec;
  pa_pkg::pa_dec_t              dec_q;

  // walk counters
  logic [pa_pkg::CNT_W-1:0]     iss;
  logic                         rd_pend;
  logic [pa_pkg::IDX_W-1:0]     rd_idx;
  logic [pa_pkg::CNT_W-1:0]     run_len;
  logic [pa_pkg::IDX_W-1:0]     run_start;
  logic [pa_pkg::NUM_W-1:0]     fill_left;
  logic [pa_pkg::IDX_W-1:0]     ptr;

  // result under construction
  logic [pa_pkg::ADDR_W-1:0]    res_addr;
  logic [pa_pkg::STAT_W-1:0]    res_status;
  logic [pa_pkg::REF_W-1:0]     res_count;

  // count ram ports
  logic                         ram_we;
  logic [pa_pkg::IDX_W-1:0]     ram_waddr;
  logic [pa_pkg::REF_W-1:0]     ram_wdata;
  logic [pa_pkg::IDX_W-1:0]     ram_raddr;
  logic [pa_pkg::REF_W-1:0]     ram_rdata;

  logic                         rd_zero;
  logic                         scan_hit;
  logic                         issue;
  logic [31:0]                  lim;
  logic                         bump_ok;
  logic                         out_free;

  pa_decode u_decode (
    .req       (req),
    .pool_base (pool_base),
    .dec       (dec)
  );

  pa_ram #(
    .WIDTH (pa_pkg::REF_W),
    .DEPTH (pa_pkg::PAGES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rd_zero  = rd_pend && (ram_rdata == '0);
    // a run long enough closes with the page now returning
    scan_hit = rd_zero && ((32'(run_len) + 32'd1) >= 32'(req.page_count));
    lim      = (32'(bump_limit) < 32'(pa_pkg::PAGES)) ? 32'(bump_limit) : 32'(pa_pkg::PAGES);
    bump_ok  = (32'(frontier) <= lim) && (32'(req.page_count) <= (lim - 32'(frontier)));
    issue    = 1'b0;
    ram_raddr = iss[pa_pkg::IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        issue = (32'(iss) < 32'(frontier)) && !scan_hit;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = pa_pkg::REF_W'(1);
      end
      S_FCHK: begin
        issue     = (32'(iss) < 32'(req.page_count)) && !rd_zero;
        ram_raddr = dec_q.page_idx + iss[pa_pkg::IDX_W-1:0];
      end
      S_FDEC: begin
        issue     = 32'(iss) < 32'(req.page_count);
        ram_raddr = dec_q.page_idx + iss[pa_pkg::IDX_W-1:0];
        ram_we    = rd_pend;
        ram_waddr = rd_idx;
        ram_wdata = ram_rdata - pa_pkg::REF_W'(1);
      end
      S_RREAD: begin
        ram_raddr = dec_q.page_idx;
      end
      S_RMW: begin
        ram_waddr = dec_q.page_idx;
        if (ram_rdata != '0) begin
          if (req.command == pa_pkg::CMD_INC) begin
            ram_we    = ram_rdata != '1;
            ram_wdata = ram_rdata + pa_pkg::REF_W'(1);
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata - pa_pkg::REF_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      bump_limit <= pa_pkg::LIM_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pa_pkg::REG_POOL_BASE:  pool_base  <= cfg_data;
        pa_pkg::REG_BUMP_LIMIT: bump_limit <= cfg_data[pa_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid               <= 1'b1;
      out_data.result_address <= res_addr;
      out_data.status         <= res_status;
      out_data.ref_count      <= res_count;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      frontier <= '0;
      ptr      <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= ram_raddr;
        iss    <= iss + pa_pkg::CNT_W'(1);
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + pa_pkg::IDX_W'(1);
          if (32'(ptr) == 32'(pa_pkg::PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          dec_q      <= dec;
          res_addr   <= '0;
          res_status <= pa_pkg::ST_OK;
          res_count  <= '0;
          iss        <= '0;
          run_len    <= '0;
          case (req.command)
            pa_pkg::CMD_ALLOC: begin
              if (req.page_count == '0) begin
                res_status <= pa_pkg::ST_BAD;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            pa_pkg::CMD_FREE: begin
              if (!dec.free_ok) begin
                res_status <= pa_pkg::ST_BAD;
                state      <= S_DONE;
              end else begin
                state <= S_FCHK;
              end
            end
            default: begin
              if (!dec.ref_ok) begin
                res_status <= pa_pkg::ST_BAD;
                state      <= S_DONE;
              end else begin
                state <= S_RREAD;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (rd_zero) begin
              run_len <= run_len + pa_pkg::CNT_W'(1);
              if (run_len == '0) begin
                run_start <= rd_idx;
              end
            end else begin
              run_len <= '0;
            end
          end
          if (scan_hit) begin
            // first fit found below the frontier
            ptr       <= (run_len == '0) ? rd_idx : run_start;
            run_start <= (run_len == '0) ? rd_idx : run_start;
            fill_left <= req.page_count;
            state     <= S_FILL;
          end else if (!rd_pend && !(32'(iss) < 32'(frontier))) begin
            state <= S_BUMP;
          end
        end
        S_BUMP: begin
          if (bump_ok) begin
            ptr       <= frontier[pa_pkg::IDX_W-1:0];
            run_start <= frontier[pa_pkg::IDX_W-1:0];
            fill_left <= req.page_count;
            frontier  <= frontier + pa_pkg::CNT_W'(req.page_count);
            state     <= S_FILL;
          end else begin
            res_status <= pa_pkg::ST_NOSPACE;
            state      <= S_DONE;
          end
        end
        S_FILL: begin
          ptr       <= ptr + pa_pkg::IDX_W'(1);
          fill_left <= fill_left - pa_pkg::NUM_W'(1);
          if (fill_left == pa_pkg::NUM_W'(1)) begin
            res_addr <= pool_base + (pa_pkg::ADDR_W'(run_start) << pa_pkg::OFF_W);
            state    <= S_DONE;
          end
        end
        S_FCHK: begin
          if (rd_zero) begin
            res_status <= pa_pkg::ST_FREED;
            state      <= S_DONE;
          end else if (!rd_pend && !(32'(iss) < 32'(req.page_count))) begin
            iss   <= '0;
            state <= S_FDEC;
          end
        end
        S_FDEC: begin
          if (!rd_pend && !(32'(iss) < 32'(req.page_count))) begin
            state <= S_DONE;
          end
        end
        S_RREAD: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (ram_rdata == '0) begin
            res_status <= pa_pkg::ST_FREED;
          end else if (req.command == pa_pkg::CMD_INC) begin
            if (ram_rdata == '1) begin
              res_status <= pa_pkg::ST_SAT;
              res_count  <= ram_rdata;
            end else begin
              res_count <= ram_rdata + pa_pkg::REF_W'(1);
            end
          end else begin
            res_count <= ram_rdata - pa_pkg::REF_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ram_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_FILL || state == S_FDEC || state == S_RMW))
    else $error("count ram written outside a write phase");

  a_frontier_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> frontier >= $past(frontier))
    else $error("frontier moved down");

  a_frontier_in_pool: assert property (@(posedge clk) disable iff (rst)
    32'(frontier) <= 32'(pa_pkg::PAGES))
    else $error("frontier beyond pool");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= pa_pkg::ST_SAT)
    else $error("illegal status code");

endmodule
